// ----- sv/dtsw_pkg.sv -----
// shared types and constants for the double threshold sequence window block
package dtsw_pkg;

    localparam int unsigned TIME_BINS = 128;
    localparam int unsigned ANODES    = 256;

    localparam logic [6:0] LAST_BIN    = 7'(TIME_BINS - 1);
    localparam logic [7:0] RAW_ANODE_A = 8'd1;
    localparam logic [7:0] RAW_ANODE_B = 8'd238;
    localparam logic [7:0] CNT_MAX     = 8'd255;

    localparam logic [2:0] CFG_LOW_LEVEL      = 3'd0;
    localparam logic [2:0] CFG_HIGH_LEVEL     = 3'd1;
    localparam logic [2:0] CFG_MIN_HIGH_COUNT = 3'd2;
    localparam logic [2:0] CFG_MIN_LENGTH     = 3'd3;
    localparam logic [2:0] CFG_EXTEND_BEFORE  = 3'd4;
    localparam logic [2:0] CFG_EXTEND_AFTER   = 3'd5;
    localparam logic [2:0] CFG_CLEAR_BINS     = 3'd6;
    localparam logic [2:0] CFG_OPTIONS        = 3'd7;

    localparam int unsigned OPT_KILL_BAD = 0;
    localparam int unsigned OPT_RAW_A    = 1;
    localparam int unsigned OPT_RAW_B    = 2;

    typedef struct packed {
        logic [7:0] low_level;
        logic [7:0] high_level;
        logic [7:0] min_high_count;
        logic [7:0] min_length;
        logic [6:0] extend_before;
        logic [6:0] extend_after;
        logic [7:0] clear_bins;
        logic [2:0] options;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        low_level:      8'd22,
        high_level:     8'd27,
        min_high_count: 8'd0,
        min_length:     8'd2,
        extend_before:  7'd1,
        extend_after:   7'd4,
        clear_bins:     8'd2,
        options:        3'd1
    };

    typedef struct packed {
        logic [7:0] adc;
        logic [6:0] time_bin;
        logic [7:0] anode;
        logic       anode_bad;
    } t_item;

    typedef struct packed {
        logic [7:0] run_length;
        logic [7:0] high_count;
        logic [6:0] run_start;
    } t_state;

    typedef struct packed {
        logic [7:0] window_anode;
        logic [6:0] window_start;
        logic [6:0] window_end;
        logic       raw_window;
    } t_result;

endpackage

// ----- sv/double_threshold_sequence_window.sv -----
// top level: config registers, input register, run state and result register
// path: a sample beat is held in the input register, and its window beat is registered in the result register
// throughput: one sample beat per cycle through the combinational step between the registers, unless stalled
// back-pressure from the result port stalls the input register only when a window is waiting
// reset: synchronous active-low; run state cleared, config back to its defaults
// config beats are always taken and apply to later samples
module double_threshold_sequence_window (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_adc,
    input  logic [6:0] i_time_bin,
    input  logic [7:0] i_anode,
    input  logic       i_anode_bad,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_window_anode,
    output logic [6:0] o_window_start,
    output logic [6:0] o_window_end,
    output logic       o_raw_window
);
    import dtsw_pkg::*;

    t_cfg    r_cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    n_emit;
    logic    advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready || !n_emit);
    assign o_in_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOW_LEVEL:      r_cfg.low_level      <= i_cfg_data;
                CFG_HIGH_LEVEL:     r_cfg.high_level     <= i_cfg_data;
                CFG_MIN_HIGH_COUNT: r_cfg.min_high_count <= i_cfg_data;
                CFG_MIN_LENGTH:     r_cfg.min_length     <= i_cfg_data;
                CFG_EXTEND_BEFORE:  r_cfg.extend_before  <= i_cfg_data[6:0];
                CFG_EXTEND_AFTER:   r_cfg.extend_after   <= i_cfg_data[6:0];
                CFG_CLEAR_BINS:     r_cfg.clear_bins     <= i_cfg_data;
                CFG_OPTIONS:        r_cfg.options        <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    dtsw_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_emit   (n_emit),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= '{adc: i_adc, time_bin: i_time_bin, anode: i_anode,
                      anode_bad: i_anode_bad};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && n_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_window_anode = r_out.window_anode;
    assign o_window_start = r_out.window_start;
    assign o_window_end   = r_out.window_end;
    assign o_raw_window   = r_out.raw_window;

    a_raw_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.raw_window |->
            r_out.window_start == 7'd0 && r_out.window_end == LAST_BIN)
        else $error("raw window beat does not span the whole anode");

    a_run_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.time_bin == LAST_BIN |=> r_state.run_length == 8'd0)
        else $error("run left open after the last time bin");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !o_in_ready |-> r_out_valid && !i_out_ready && n_emit)
        else $error("input stalled without a waiting window beat");

endmodule

// ----- sv/dtsw_step.sv -----
// run tracking, qualification, window widening and raw-anode beats for one sample
module dtsw_step (
    input  dtsw_pkg::t_cfg    i_cfg,
    input  dtsw_pkg::t_state  i_state,
    input  dtsw_pkg::t_item   i_item,
    output dtsw_pkg::t_state  o_state,
    output logic              o_emit,
    output dtsw_pkg::t_result o_result
);
    import dtsw_pkg::*;

    logic       bin_zero;
    logic       kill_bad;
    logic       is_raw;
    logic [7:0] adc_eff;
    logic [7:0] rl0;
    logic [7:0] hc0;
    logic [7:0] hc1;
    logic [7:0] rl1;
    logic [6:0] start;
    logic [6:0] end_bin;
    logic       close;
    logic       keep;
    logic [7:0] end_wide;
    logic [6:0] win_start;
    logic [6:0] win_end;

    always_comb begin
        bin_zero = (i_item.time_bin == 7'd0);
        kill_bad = i_cfg.options[OPT_KILL_BAD] && i_item.anode_bad;
        is_raw   = (i_item.anode == RAW_ANODE_A && i_cfg.options[OPT_RAW_A]) ||
                   (i_item.anode == RAW_ANODE_B && i_cfg.options[OPT_RAW_B]);
        rl0 = bin_zero ? 8'd0 : i_state.run_length;
        hc0 = bin_zero ? 8'd0 : i_state.high_count;

        adc_eff = (({1'b0, i_item.time_bin} < i_cfg.clear_bins) || kill_bad) ?
                  8'd0 : i_item.adc;

        hc1 = (adc_eff > i_cfg.high_level && hc0 != CNT_MAX) ? hc0 + 8'd1 : hc0;
        rl1     = rl0;
        start   = i_state.run_start;
        end_bin = i_item.time_bin - 7'd1;
        close   = 1'b0;

        o_state = '{run_length: rl0, high_count: hc1, run_start: i_state.run_start};

        if (adc_eff > i_cfg.low_level) begin
            if (rl0 == 8'd0) begin
                start = i_item.time_bin;
            end
            rl1 = (rl0 != CNT_MAX) ? rl0 + 8'd1 : rl0;
            o_state.run_start  = start;
            o_state.run_length = rl1;
            if (i_item.time_bin == LAST_BIN) begin
                close   = 1'b1;
                end_bin = i_item.time_bin;
            end
        end else if (rl0 != 8'd0) begin
            close = 1'b1;
        end else if (i_item.time_bin == LAST_BIN) begin
            o_state.high_count = 8'd0;
        end

        keep = (hc1 > i_cfg.min_high_count) && (rl1 > i_cfg.min_length);
        if (close) begin
            o_state.run_length = 8'd0;
            o_state.high_count = 8'd0;
        end

        win_start = (start > i_cfg.extend_before) ? start - i_cfg.extend_before : 7'd0;
        end_wide  = {1'b0, end_bin} + {1'b0, i_cfg.extend_after};
        win_end   = (end_wide > {1'b0, LAST_BIN}) ? LAST_BIN : end_wide[6:0];

        o_emit   = close && keep && !is_raw;
        o_result = '{window_anode: i_item.anode, window_start: win_start,
                     window_end: win_end, raw_window: 1'b0};

        if (is_raw && bin_zero && !kill_bad) begin
            o_emit   = 1'b1;
            o_result = '{window_anode: i_item.anode, window_start: 7'd0,
                         window_end: LAST_BIN, raw_window: 1'b1};
        end
    end

endmodule
